// ===== src/semr_pkg.sv =====
// Shared types and constants of the RGB Sobel edge-magnitude core.
// No dependencies; the controller, datapath, top and testbench import this package.
`default_nettype none
package semr_pkg;

   // frame geometry
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;
   localparam int WID_W      = 12;                  // frame_width register
   localparam int HGT_W      = 13;                  // frame_height register
   localparam int CSR_W      = 13;                  // widest register
   localparam int COL_W      = $clog2(MAX_WIDTH);   // line store address
   localparam int PIX_W      = 24;                  // packed RGB
   localparam int CH_W       = 8;

   // magnitude arithmetic
   localparam int SUM_W      = 21;                  // gx^2 + gy^2
   localparam int ABS_W      = 10;                  // |gx|, |gy| <= 1020
   localparam int REM_W      = 10;
   localparam int ROOT_STEPS = 8;
   localparam logic [SUM_W-1:0] MAG_LIMIT = SUM_W'(65280);
   localparam logic [CH_W-1:0]  MAG_CLAMP = 8'd255;

   localparam logic [WID_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;

   // register indexes
   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_UPDATE,
      S_GRAD,
      S_SQUARE,
      S_ROOT,
      S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;     // keep the accepted item
      logic       restart;     // accepted pixel after a finished frame
      logic       mem_read;
      logic       update;      // line store write, window shift, counters
      logic       grad;
      logic       square;
      logic [1:0] chan;
      logic       root_step;
      logic       root_first;
      logic       load_out;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic finished;          // all results of the frame given
      logic skip;              // drain item on a finished frame
      logic has_result;        // current item emits a result
      logic out_busy;          // result register held by a stalled receiver
   } status_type;

endpackage
`default_nettype wire

// ===== src/semr_req_if.sv =====
// Input channel of the Sobel core: valid/ready handshake, mode and RGB pixel.
// Depends on nothing.
`default_nettype none
interface semr_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] pixel_red;
   logic [7:0] pixel_green;
   logic [7:0] pixel_blue;

   modport source (output valid, mode, pixel_red, pixel_green, pixel_blue, input ready);
   modport sink   (input valid, mode, pixel_red, pixel_green, pixel_blue, output ready);
endinterface
`default_nettype wire

// ===== src/semr_rsp_if.sv =====
// Result channel of the Sobel core: valid/ready handshake, edge magnitudes.
// Depends on nothing.
`default_nettype none
interface semr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] edge_red;
   logic [7:0] edge_green;
   logic [7:0] edge_blue;
   logic       last_of_frame;

   modport source (output valid, edge_red, edge_green, edge_blue, last_of_frame,
                   input ready);
   modport sink   (input valid, edge_red, edge_green, edge_blue, last_of_frame,
                   output ready);
endinterface
`default_nettype wire

// ===== src/semr_ctrl.sv =====
// Sequencer of the Sobel core: walks one item through lookup, update and, if it
// has a result, gradient, squaring, square root and result load. Uses semr_pkg.
`default_nettype none
module semr_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  semr_pkg::status_type  status,
   output semr_pkg::cmd_type     cmd
);
   import semr_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;

   // next state; ready is high only in S_IDLE, so a transfer there is req_valid
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !status.skip) state_in = S_LOOK;
         end
         S_LOOK:   state_in = S_UPDATE;
         S_UPDATE: state_in = status.has_result ? S_GRAD : S_IDLE;
         S_GRAD: begin
            state_in = S_SQUARE;
            cnt_in   = '0;
         end
         S_SQUARE: begin
            if (cnt_ff == 3'd2) begin
               state_in = S_ROOT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         S_ROOT: begin
            if (cnt_ff == 3'(ROOT_STEPS - 1)) state_in = S_DONE;
            cnt_in = cnt_ff + 3'd1;
         end
         S_DONE: begin
            if (!status.out_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid && !status.skip;
            cmd.restart = req_valid && !status.skip && status.finished;
         end
         S_LOOK:   cmd.mem_read = 1'b1;
         S_UPDATE: cmd.update   = 1'b1;
         S_GRAD:   cmd.grad     = 1'b1;
         S_SQUARE: begin
            cmd.square = 1'b1;
            cmd.chan   = cnt_ff[1:0];
         end
         S_ROOT: begin
            cmd.root_step  = 1'b1;
            cmd.root_first = (cnt_ff == 3'd0);
         end
         S_DONE:   cmd.load_out = !status.out_busy;
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/semr_datapath.sv =====
// Datapath of the Sobel core: registers, frame counters, two-row line store,
// 3x3 window, gradients, squares, bit-serial square roots, result register.
// Uses semr_pkg.
`default_nettype none
module semr_datapath (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_we,
   input  wire                          csr_index,
   input  wire [semr_pkg::CSR_W-1:0]    csr_wdata,
   input  wire                          req_mode,
   input  wire [7:0]                    req_red,
   input  wire [7:0]                    req_green,
   input  wire [7:0]                    req_blue,
   input  wire                          rsp_ready,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_red,
   output logic [7:0]                   rsp_green,
   output logic [7:0]                   rsp_blue,
   output logic                         rsp_last,
   input  semr_pkg::cmd_type            cmd,
   output semr_pkg::status_type         status
);
   import semr_pkg::*;

   // configuration
   logic [WID_W-1:0] width_ff;
   logic [HGT_W-1:0] height_ff;
   logic [WID_W-1:0] w_eff;
   logic [HGT_W-1:0] h_eff;

   always_comb begin
      if (width_ff == '0)                     w_eff = WID_W'(1);
      else if (width_ff > WID_W'(MAX_WIDTH))  w_eff = WID_W'(MAX_WIDTH);
      else                                    w_eff = width_ff;
      if (height_ff == '0)                    h_eff = HGT_W'(1);
      else if (height_ff > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
      else                                    h_eff = height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_FRAME_WIDTH:  width_ff  <= csr_wdata[WID_W-1:0];
            REG_FRAME_HEIGHT: height_ff <= csr_wdata[HGT_W-1:0];
            default: ;
         endcase
      end
   end

   // frame counters: input column/row, warm-up count, output column/row
   logic [COL_W-1:0] q_ff, q_in;
   logic [HGT_W-1:0] in_row_ff, in_row_in;
   logic [WID_W:0]   warm_ff, warm_in;
   logic [COL_W-1:0] ox_ff, ox_in;
   logic [HGT_W-1:0] oy_ff, oy_in;
   logic             warm_done, finished;
   logic             q_wrap;

   assign warm_done = (warm_ff == ({1'b0, w_eff} + 1'b1));
   assign finished  = warm_done && (oy_ff == h_eff);
   assign q_wrap    = ({1'b0, q_ff} == (w_eff - 1'b1));

   // captured item
   logic             mode_ff;
   logic [PIX_W-1:0] pix_ff;
   logic [PIX_W-1:0] pix;

   assign pix = (!mode_ff && (in_row_ff < h_eff)) ? pix_ff : '0;

   // result position flags of the current item
   logic top_ff, bot_ff, left_ff, right_ff, last_ff;

   always_comb begin
      q_in      = q_ff;
      in_row_in = in_row_ff;
      warm_in   = warm_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      if (csr_we || cmd.restart) begin
         q_in      = '0;
         in_row_in = '0;
         warm_in   = '0;
         ox_in     = '0;
         oy_in     = '0;
      end else if (cmd.update) begin
         if (q_wrap) begin
            q_in = '0;
            if (in_row_ff < h_eff) in_row_in = in_row_ff + 1'b1;
         end else begin
            q_in = q_ff + 1'b1;
         end
         if (warm_done) begin
            if ({1'b0, ox_ff} == (w_eff - 1'b1)) begin
               ox_in = '0;
               oy_in = oy_ff + 1'b1;
            end else begin
               ox_in = ox_ff + 1'b1;
            end
         end else begin
            warm_in = warm_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff      <= '0;
         in_row_ff <= '0;
         warm_ff   <= '0;
         ox_ff     <= '0;
         oy_ff     <= '0;
      end else begin
         q_ff      <= q_in;
         in_row_ff <= in_row_in;
         warm_ff   <= warm_in;
         ox_ff     <= ox_in;
         oy_ff     <= oy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         pix_ff  <= {req_red, req_green, req_blue};
      end
      if (cmd.update && warm_done) begin
         top_ff   <= (oy_ff == '0);
         bot_ff   <= (oy_ff == (h_eff - 1'b1));
         left_ff  <= (ox_ff == '0);
         right_ff <= ({1'b0, ox_ff} == (w_eff - 1'b1));
         last_ff  <= (oy_ff == (h_eff - 1'b1)) && ({1'b0, ox_ff} == (w_eff - 1'b1));
      end
   end

   // line store: word holds {one row up, two rows up} for each column
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] line_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_read) line_rd_ff <= line_mem[q_ff];
      if (cmd.update)   line_mem[q_ff] <= {pix, line_rd_ff[2*PIX_W-1:PIX_W]};
   end

   // 3x3 window, row-major, column 2 is the newest
   logic [PIX_W-1:0] win_ff [9];

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3]   <= win_ff[r*3+1];
            win_ff[r*3+1] <= win_ff[r*3+2];
         end
         win_ff[2] <= line_rd_ff[PIX_W-1:0];
         win_ff[5] <= line_rd_ff[2*PIX_W-1:PIX_W];
         win_ff[8] <= pix;
      end
   end

   // gradients: absolute values per channel
   logic [ABS_W-1:0] gx_ff [3];
   logic [ABS_W-1:0] gy_ff [3];
   logic [CH_W-1:0]  p [3][9];
   logic [ABS_W-1:0] xp [3], xn [3], yp [3], yn [3];

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         logic ok;
         ok = !(((i / 3) == 0 && top_ff) || ((i / 3) == 2 && bot_ff) ||
                ((i % 3) == 0 && left_ff) || ((i % 3) == 2 && right_ff));
         for (int c = 0; c < 3; c++) begin
            p[c][i] = ok ? win_ff[i][(2-c)*CH_W +: CH_W] : '0;
         end
      end
      for (int c = 0; c < 3; c++) begin
         xp[c] = ABS_W'(p[c][2]) + {1'b0, p[c][5], 1'b0} + ABS_W'(p[c][8]);
         xn[c] = ABS_W'(p[c][0]) + {1'b0, p[c][3], 1'b0} + ABS_W'(p[c][6]);
         yp[c] = ABS_W'(p[c][6]) + {1'b0, p[c][7], 1'b0} + ABS_W'(p[c][8]);
         yn[c] = ABS_W'(p[c][0]) + {1'b0, p[c][1], 1'b0} + ABS_W'(p[c][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.grad) begin
         for (int c = 0; c < 3; c++) begin
            gx_ff[c] <= (xp[c] >= xn[c]) ? xp[c] - xn[c] : xn[c] - xp[c];
            gy_ff[c] <= (yp[c] >= yn[c]) ? yp[c] - yn[c] : yn[c] - yp[c];
         end
      end
   end

   // sum of squares, one channel per cycle
   logic [SUM_W-1:0] sum_ff [3];
   logic [1:0]       ch;

   assign ch = (cmd.chan > 2'd2) ? 2'd2 : cmd.chan;

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sum_ff[ch] <= SUM_W'(gx_ff[ch] * gx_ff[ch]) + SUM_W'(gy_ff[ch] * gy_ff[ch]);
      end
   end

   // restoring square root, two radicand bits per step, three channels at once
   logic [15:0]      rad_ff  [3];
   logic [REM_W-1:0] rem_ff  [3];
   logic [CH_W-1:0]  root_ff [3];

   always_ff @(posedge clock) begin
      if (cmd.root_step) begin
         for (int c = 0; c < 3; c++) begin
            logic [15:0]      rad_s;
            logic [REM_W-1:0] rem_s;
            logic [CH_W-1:0]  root_s;
            logic [REM_W+1:0] acc, trial;
            rad_s  = cmd.root_first ? sum_ff[c][15:0] : rad_ff[c];
            rem_s  = cmd.root_first ? '0 : rem_ff[c];
            root_s = cmd.root_first ? '0 : root_ff[c];
            acc    = {rem_s, rad_s[15:14]};
            trial  = {2'b00, root_s, 2'b01};
            if (acc >= trial) begin
               rem_ff[c]  <= REM_W'(acc - trial);
               root_ff[c] <= {root_s[CH_W-2:0], 1'b1};
            end else begin
               rem_ff[c]  <= acc[REM_W-1:0];
               root_ff[c] <= {root_s[CH_W-2:0], 1'b0};
            end
            rad_ff[c] <= {rad_s[13:0], 2'b00};
         end
      end
   end

   // rounding and clamp
   logic [CH_W-1:0] mag [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (sum_ff[c] > MAG_LIMIT) mag[c] = MAG_CLAMP;
         else mag[c] = root_ff[c] + CH_W'(rem_ff[c] > REM_W'(root_ff[c]));
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_red   <= mag[0];
         rsp_green <= mag[1];
         rsp_blue  <= mag[2];
         rsp_last  <= last_ff;
      end
   end

   assign status.finished   = finished;
   assign status.skip       = finished && req_mode;
   assign status.has_result = warm_done;
   assign status.out_busy   = rsp_valid && !rsp_ready;

endmodule
`default_nettype wire

// ===== src/sobel_edge_magnitude_rgb_core.sv =====
// RGB Sobel edge-magnitude core, 3x3 kernels on a raster stream.
// Channels: req_ch takes one pixel (mode 0) or drain item (mode 1) per
// transfer; rsp_ch gives edge_red/green/blue and last_of_frame. The result
// for pixel k comes with the transfer of item k+width+1; after a frame send
// width+1 drain items. csr_we/csr_index/csr_wdata set frame_width (index 0)
// and frame_height (index 1) and restart the frame; write only when idle.
// Sequence: an item that gives no result passes through accept, line store
// read and update. An item with a result goes on through gradient, a squaring
// step per channel, 8 square-root steps and the load of the result register,
// which waits while the receiver still holds the previous one. A drain item
// on a finished frame is taken and dropped while the sequencer stays idle.
// The result register holds a result while the receiver stalls; the next
// item is still taken and runs until it must load that register.
// Reset (synchronous) restores 640x480 and an empty frame. The line store
// needs no clearing: rows outside the frame are masked to zero.
// Uses semr_pkg, semr_req_if, semr_rsp_if, semr_ctrl, semr_datapath.
`default_nettype none
module sobel_edge_magnitude_rgb_core (
   input  wire                        clock,
   input  wire                        reset,
   semr_req_if.sink                   req_ch,
   semr_rsp_if.source                 rsp_ch,
   input  wire                        csr_we,
   input  wire                        csr_index,
   input  wire [semr_pkg::CSR_W-1:0]  csr_wdata
);
   import semr_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       ready;

   semr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   semr_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_mode  (req_ch.mode),
      .req_red   (req_ch.pixel_red),
      .req_green (req_ch.pixel_green),
      .req_blue  (req_ch.pixel_blue),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_red   (rsp_ch.edge_red),
      .rsp_green (rsp_ch.edge_green),
      .rsp_blue  (rsp_ch.edge_blue),
      .rsp_last  (rsp_ch.last_of_frame),
      .cmd       (cmd),
      .status    (status)
   );

   assign req_ch.ready = ready;

   // a result is never loaded over one that the receiver still holds
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_ch.valid && !rsp_ch.ready))
      else $error("result register overwritten");

   // a loaded result is offered in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_ch.valid)
      else $error("loaded result not offered");

   // a kept item blocks the input until it is worked off
   a_busy_after_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_ch.ready)
      else $error("input ready while an item is in work");

endmodule
`default_nettype wire

// ===== test/sobel_edge_magnitude_rgb_core_tb.sv =====
// Testbench of the RGB Sobel edge-magnitude core: directed frames, then random frames.
// Depends on semr_pkg, semr_req_if, semr_rsp_if and sobel_edge_magnitude_rgb_core.
`timescale 1ns / 100ps
module sobel_edge_magnitude_rgb_core_tb;
   import semr_pkg::*;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int SETTLE      = 24;     // worst item latency plus margin

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } edge_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic                  csr_index = 1'b0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   semr_req_if req_ch ();
   semr_rsp_if rsp_ch ();

   sobel_edge_magnitude_rgb_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow of the block: geometry, rows, window, frame position
   logic [WID_W-1:0] shadow_width  = WIDTH_RESET;
   logic [HGT_W-1:0] shadow_height = HEIGHT_RESET;
   logic [PIX_W-1:0] row_mem [0:2*MAX_WIDTH-1];
   logic [PIX_W-1:0] win [0:8];
   int unsigned      frame_pos = 0;

   edge_result_type pending_edges[$];
   int  mismatches   = 0;
   int  edges_seen   = 0;
   int  items_sent   = 0;
   int  frames_sent  = 0;
   int  cycle_count  = 0;
   int  burst_left   = 0;
   bit  hold_req     = 1'b0;
   bit  hold_ack     = 1'b0;
   int  hold_left    = 0;
   int  ready_pct    = 100;

   // rounded square root of gx^2+gy^2, clamped at 255
   function automatic logic [7:0] edge_mag(input int p[9]);
      int gx, gy, n, t;
      int unsigned s;
      gx = (p[2] + 2*p[5] + p[8]) - (p[0] + 2*p[3] + p[6]);
      gy = (p[6] + 2*p[7] + p[8]) - (p[0] + 2*p[1] + p[2]);
      s  = gx*gx + gy*gy;
      if (s > 65280) return 8'd255;
      n = 0;
      for (int b = 7; b >= 0; b--) begin
         t = n | (1 << b);
         if (t*t <= s) n = t;
      end
      if (s > n*n + n) n++;
      return (n > 255) ? 8'd255 : n[7:0];
   endfunction

   // advance the shadow by one accepted item; queue the edge it yields
   function automatic void track_item(input logic drain, input logic [23:0] rgb);
      int unsigned w, h, n, c, q, k, x, y;
      logic [PIX_W-1:0] pix, above, above2, v;
      int pr[9], pg[9], pb[9];
      bit ok;
      edge_result_type e;
      w = (shadow_width == 0) ? 1 : (shadow_width > MAX_WIDTH) ? MAX_WIDTH : shadow_width;
      h = (shadow_height == 0) ? 1 : (shadow_height > MAX_HEIGHT) ? MAX_HEIGHT : shadow_height;
      n = w * h;
      if (frame_pos >= n + w + 1) begin
         if (drain) return;
         frame_pos = 0;
      end
      c   = frame_pos;
      pix = (!drain && c < n) ? rgb : '0;
      q      = c % w;
      above2 = row_mem[MAX_WIDTH + q];
      above  = row_mem[q];
      row_mem[MAX_WIDTH + q] = above;
      row_mem[q]             = pix;
      for (int i = 0; i < 3; i++) begin
         win[i*3]   = win[i*3+1];
         win[i*3+1] = win[i*3+2];
      end
      win[2] = above2;
      win[5] = above;
      win[8] = pix;
      frame_pos = c + 1;
      if (c < w + 1) return;
      k = c - w - 1;
      if (k >= n) return;
      y = k / w;
      x = k % w;
      for (int i = 0; i < 9; i++) begin
         ok = 1'b1;
         if (i / 3 == 0 && y == 0) ok = 1'b0;
         if (i / 3 == 2 && y + 1 >= h) ok = 1'b0;
         if (i % 3 == 0 && x == 0) ok = 1'b0;
         if (i % 3 == 2 && x + 1 >= w) ok = 1'b0;
         v = ok ? win[i] : '0;
         pr[i] = int'(v[23:16]);
         pg[i] = int'(v[15:8]);
         pb[i] = int'(v[7:0]);
      end
      e.red   = edge_mag(pr);
      e.green = edge_mag(pg);
      e.blue  = edge_mag(pb);
      e.last  = (k == n - 1);
      pending_edges.push_back(e);
   endfunction

   // one item over the request channel, with burst/gap pacing
   task automatic send_item(input logic drain, input logic [23:0] rgb);
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= drain;
      req_ch.pixel_red   <= rgb[23:16];
      req_ch.pixel_green <= rgb[15:8];
      req_ch.pixel_blue  <= rgb[7:0];
      do @(posedge clock); while (!req_ch.ready);
      track_item(drain, rgb);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   function automatic logic [23:0] rand_rgb();
      logic [23:0] v;
      v = 24'($urandom);
      for (int i = 0; i < 3; i++)
         case ($urandom_range(0, 7))
            0: v[i*8 +: 8] = 8'h00;
            1: v[i*8 +: 8] = 8'hff;
            default: ;
         endcase
      return v;
   endfunction

   // pause the sender until every expected edge is back, then let the core settle
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input int value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_FRAME_WIDTH) shadow_width = value[WID_W-1:0];
      else                        shadow_height = value[HGT_W-1:0];
      frame_pos = 0;
   endtask

   task automatic set_geometry(input int w, input int h);
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
   endtask

   // full frame; glitch_pct flips the mode of some items
   task automatic send_frame(input int w, input int h, input int glitch_pct);
      logic drain;
      for (int i = 0; i < w*h + w + 1; i++) begin
         drain = (i >= w*h);
         if ($urandom_range(0, 99) < glitch_pct) drain = !drain;
         send_item(drain, rand_rgb());
      end
      frames_sent++;
   endtask

   task automatic test_reset_geometry();
      // default 640x480: enough items for the first edges of row 0
      for (int i = 0; i < 648; i++) send_item(1'b0, rand_rgb());
   endtask

   task automatic test_tiny_frames();
      set_geometry(0, 0);           // acts as 1x1
      send_item(1'b0, 24'hffffff);
      send_item(1'b1, 24'h0);
      send_item(1'b1, 24'h0);
      send_item(1'b1, 24'h0);       // finished frame: dropped
      set_geometry(3, 3);
      for (int i = 0; i < 9; i++)
         send_item(1'b0, (i % 2) ? 24'hffffff : 24'h000000);
      for (int i = 0; i < 4; i++) send_item(1'b1, 24'h0);
   endtask

   task automatic test_frame_corner_cases();
      set_geometry(4, 3);
      send_item(1'b0, 24'h80ff00);
      send_item(1'b1, 24'hffffff);  // drain inside the frame counts as black
      for (int i = 0; i < 10; i++) send_item(1'b0, rand_rgb());
      send_item(1'b1, 24'h0);
      send_item(1'b0, 24'hffffff);  // pixel while draining is a drain
      for (int i = 0; i < 3; i++) send_item(1'b1, 24'h0);
      send_item(1'b1, 24'h0);       // after the frame: no edge
      send_item(1'b0, 24'h123456);  // starts the next frame
      for (int i = 0; i < 5; i++) send_item(1'b0, rand_rgb());
      write_reg(REG_FRAME_HEIGHT, 2);  // restart mid-frame
      send_frame(4, 2, 0);
   endtask

   task automatic test_widest_row();
      set_geometry(4095, 1);        // clamps to the maximum width
      // still inside the first row: no edge may appear
      for (int i = 0; i < 30; i++) send_item(1'b0, rand_rgb());
   endtask

   task automatic test_tallest_column();
      set_geometry(1, 8191);        // clamps to the maximum height
      for (int i = 0; i < 40; i++) send_item(1'b0, rand_rgb());
      set_geometry(2048, 2);
      for (int i = 0; i < 30; i++) send_item(1'b0, rand_rgb());
   endtask

   task automatic test_backpressure();
      set_geometry(5, 4);
      hold_req = !hold_req;         // receiver stops for a long stretch
      send_frame(5, 4, 0);
      wait_drained();
   endtask

   task automatic test_random_frames();
      int w, h, start;
      start = items_sent;
      while (items_sent - start < 260) begin
         if ($urandom_range(0, 9) < 3) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            set_geometry(w, h);
         end
         w = (shadow_width == 0) ? 1 : shadow_width;
         h = (shadow_height == 0) ? 1 : shadow_height;
         if ($urandom_range(0, 19) == 0) hold_req = !hold_req;
         case ($urandom_range(0, 9))
            0:       for (int i = 0; i < $urandom_range(1, 12); i++)
                        send_item(1'($urandom_range(0, 1)), rand_rgb());
            1:       send_frame(w, h, 10);
            default: send_frame(w, h, 0);
         endcase
         if ($urandom_range(0, 4) == 0) send_item(1'b1, rand_rgb());
      end
      wait_drained();
   endtask

   // receiver: ready pattern plus an occasional long hold-off
   always @(posedge clock) begin
      if (cycle_count % 300 == 0) ready_pct <= ($urandom_range(0, 2) == 0) ? 100
                                                : $urandom_range(20, 90);
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left <= 400;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) < ready_pct);
      end
   end

   // check each edge transfer against the oldest expectation
   always @(posedge clock) begin
      edge_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         edges_seen++;
         if (pending_edges.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected edge r=%0d g=%0d b=%0d last=%0d", rsp_ch.edge_red,
                        rsp_ch.edge_green, rsp_ch.edge_blue, rsp_ch.last_of_frame);
         end else begin
            want = pending_edges.pop_front();
            if (rsp_ch.edge_red !== want.red || rsp_ch.edge_green !== want.green ||
                rsp_ch.edge_blue !== want.blue || rsp_ch.last_of_frame !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("edge %0d: expected r=%0d g=%0d b=%0d last=%0d, got %0d %0d %0d %0d",
                           edges_seen, want.red, want.green, want.blue, want.last,
                           rsp_ch.edge_red, rsp_ch.edge_green, rsp_ch.edge_blue,
                           rsp_ch.last_of_frame);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.mode        = 1'b0;
      req_ch.pixel_red   = '0;
      req_ch.pixel_green = '0;
      req_ch.pixel_blue  = '0;
      rsp_ch.ready       = 1'b0;
      for (int i = 0; i < 2*MAX_WIDTH; i++) row_mem[i] = '0;
      for (int i = 0; i < 9; i++) win[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_geometry();
      test_tiny_frames();
      test_frame_corner_cases();
      test_widest_row();
      test_tallest_column();
      test_backpressure();
      test_random_frames();
      $display("%0d items, %0d frames, %0d edges checked over %0d cycles",
               items_sent, frames_sent, edges_seen, cycle_count);
      $display("covered clamped geometry, drain corner cases, restarts and long stalls");
      if (mismatches == 0 && pending_edges.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d edges missing", mismatches, pending_edges.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
